>>> rtl/urac_pkg.sv
// Shared constants, types and helpers of the undo/redo accumulator unit.
`timescale 1ns / 1ps
`default_nettype none

package urac_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 5;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 3'd0,
        FUNC_SUB  = 3'd1,
        FUNC_MUL  = 3'd2,
        FUNC_DIV  = 3'd3,
        FUNC_UNDO = 3'd4,
        FUNC_REDO = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_UNDO  = 2'd1,
        ST_NO_REDO  = 2'd2,
        ST_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB,
        ACC_MUL,
        ACC_DIV,
        ACC_POP_UNDO,
        ACC_POP_REDO
    } acc_sel_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic     load;
        acc_sel_t acc_sel;
        logic     push_undo;
        logic     push_redo;
        logic     pop_undo;
        logic     pop_redo;
        logic     clear_redo;
        logic     div_start;
        logic     out_load;
        status_t  status;
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic undo_empty;
        logic redo_empty;
        logic op_zero;
        logic div_done;
    } dp_stat_t;

    // Mask or extend a stack count to the depth field width.
    function automatic logic [DEPTH_W-1:0] depth_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+DEPTH_W-1:0] wide;
        wide = {{DEPTH_W{1'b0}}, c};
        return wide[DEPTH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/urac_if.sv
// Command and response channel interfaces of the undo/redo accumulator unit.
`timescale 1ns / 1ps
`default_nettype none

interface urac_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [urac_pkg::FUNC_W-1:0]  func;
    logic signed [urac_pkg::DATA_W-1:0]  operand;

    modport source (output valid, output func, output operand, input ready);
    modport sink   (input valid, input func, input operand, output ready);
endinterface

interface urac_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [urac_pkg::DATA_W-1:0]   value;
    logic        [urac_pkg::STATUS_W-1:0] status;
    logic        [urac_pkg::DEPTH_W-1:0]  undo_depth;
    logic        [urac_pkg::DEPTH_W-1:0]  redo_depth;

    modport source (output valid, output value, output status, output undo_depth,
                    output redo_depth, input ready);
    modport sink   (input valid, input value, input status, input undo_depth,
                    input redo_depth, output ready);
endinterface

`default_nettype wire

>>> rtl/urac_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module urac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/urac_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module urac_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [urac_pkg::DATA_W-1:0] dividend,
    input  wire logic [urac_pkg::DATA_W-1:0] divisor,
    output logic                             done,
    output logic      [urac_pkg::DATA_W-1:0] quotient
);

    localparam int W = urac_pkg::DATA_W;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [urac_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]                   q_reg, q_next;
    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   d_reg, d_next;
    logic                           neg_reg, neg_next;
    logic [W-1:0]                   quot_reg, quot_next;
    logic [W:0]                     shifted;
    logic [W:0]                     diff;
    logic [W-1:0]                   q_step;

    assign shifted = {rem_reg, q_reg[W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign q_step  = {q_reg[W-2:0], ~diff[W]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (start)
        begin
            // Work on magnitudes, fix the sign at the end.
            busy_next = 1'b1;
            cnt_next  = urac_pkg::DIV_CNT_W'(W);
            q_next    = dividend[W-1] ? (W'(0) - dividend) : dividend;
            d_next    = divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_next  = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            q_next   = q_step;
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == urac_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = neg_reg ? (W'(0) - q_step) : q_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> rtl/urac_datapath.sv
// Accumulator, undo and redo stacks, divider and response registers.
`timescale 1ns / 1ps
`default_nettype none

module urac_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire urac_pkg::ctl_cmd_t            ctl,
    input  wire logic [urac_pkg::DATA_W-1:0]   operand_in,
    output urac_pkg::dp_stat_t                 stat,
    output logic      [urac_pkg::DATA_W-1:0]   value,
    output logic      [urac_pkg::STATUS_W-1:0] status,
    output logic      [urac_pkg::DEPTH_W-1:0]  undo_depth,
    output logic      [urac_pkg::DEPTH_W-1:0]  redo_depth
);

    localparam int W  = urac_pkg::DATA_W;
    localparam int PW = urac_pkg::PTR_W;
    localparam int CW = urac_pkg::CNT_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(urac_pkg::STACK_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(urac_pkg::STACK_DEPTH);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  opnd_reg;
    logic [PW-1:0] undo_top_reg, undo_top_next;
    logic [CW-1:0] undo_cnt_reg, undo_cnt_next;
    logic [PW-1:0] redo_top_reg, redo_top_next;
    logic [CW-1:0] redo_cnt_reg, redo_cnt_next;
    logic [PW-1:0] undo_top_inc, undo_top_dec;
    logic [PW-1:0] redo_top_inc, redo_top_dec;
    logic [W-1:0]  undo_rd_data, redo_rd_data;
    logic [W-1:0]  mul_lo;
    logic          div_done;
    logic [W-1:0]  div_quot;

    logic [W-1:0]                   value_reg;
    logic [urac_pkg::STATUS_W-1:0]  status_reg;
    logic [urac_pkg::DEPTH_W-1:0]   undo_depth_reg, redo_depth_reg;

    assign undo_top_inc = (undo_top_reg == LAST_SLOT) ? '0 : undo_top_reg + 1'b1;
    assign undo_top_dec = (undo_top_reg == '0) ? LAST_SLOT : undo_top_reg - 1'b1;
    assign redo_top_inc = (redo_top_reg == LAST_SLOT) ? '0 : redo_top_reg + 1'b1;
    assign redo_top_dec = (redo_top_reg == '0) ? LAST_SLOT : redo_top_reg - 1'b1;

    assign mul_lo = acc_reg * opnd_reg;

    urac_ram #(.WIDTH(W), .DEPTH(urac_pkg::STACK_DEPTH)) u_undo_ram (
        .clk     (clk),
        .wr_en   (ctl.push_undo),
        .wr_addr (undo_top_reg),
        .wr_data (acc_reg),
        .rd_en   (ctl.pop_undo),
        .rd_addr (undo_top_dec),
        .rd_data (undo_rd_data)
    );

    urac_ram #(.WIDTH(W), .DEPTH(urac_pkg::STACK_DEPTH)) u_redo_ram (
        .clk     (clk),
        .wr_en   (ctl.push_redo),
        .wr_addr (redo_top_reg),
        .wr_data (acc_reg),
        .rd_en   (ctl.pop_redo),
        .rd_addr (redo_top_dec),
        .rd_data (redo_rd_data)
    );

    urac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (acc_reg),
        .divisor  (opnd_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        unique case (ctl.acc_sel)
            urac_pkg::ACC_ADD:      acc_next = acc_reg + opnd_reg;
            urac_pkg::ACC_SUB:      acc_next = acc_reg - opnd_reg;
            urac_pkg::ACC_MUL:      acc_next = mul_lo;
            urac_pkg::ACC_DIV:      acc_next = div_quot;
            urac_pkg::ACC_POP_UNDO: acc_next = undo_rd_data;
            urac_pkg::ACC_POP_REDO: acc_next = redo_rd_data;
            default:                acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        undo_top_next = undo_top_reg;
        undo_cnt_next = undo_cnt_reg;
        redo_top_next = redo_top_reg;
        redo_cnt_next = redo_cnt_reg;
        // A push onto a full stack overwrites the oldest slot.
        if (ctl.push_undo)
        begin
            undo_top_next = undo_top_inc;
            if (undo_cnt_reg != FULL_CNT)
            begin
                undo_cnt_next = undo_cnt_reg + 1'b1;
            end
        end
        else if (ctl.pop_undo)
        begin
            undo_top_next = undo_top_dec;
            undo_cnt_next = undo_cnt_reg - 1'b1;
        end
        if (ctl.clear_redo)
        begin
            redo_top_next = '0;
            redo_cnt_next = '0;
        end
        else if (ctl.push_redo)
        begin
            redo_top_next = redo_top_inc;
            if (redo_cnt_reg != FULL_CNT)
            begin
                redo_cnt_next = redo_cnt_reg + 1'b1;
            end
        end
        else if (ctl.pop_redo)
        begin
            redo_top_next = redo_top_dec;
            redo_cnt_next = redo_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            undo_top_reg <= '0;
            undo_cnt_reg <= '0;
            redo_top_reg <= '0;
            redo_cnt_reg <= '0;
        end
        else
        begin
            acc_reg      <= acc_next;
            undo_top_reg <= undo_top_next;
            undo_cnt_reg <= undo_cnt_next;
            redo_top_reg <= redo_top_next;
            redo_cnt_reg <= redo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            opnd_reg <= operand_in;
        end
        if (ctl.out_load)
        begin
            value_reg      <= acc_reg;
            status_reg     <= ctl.status;
            undo_depth_reg <= urac_pkg::depth_field(undo_cnt_reg);
            redo_depth_reg <= urac_pkg::depth_field(redo_cnt_reg);
        end
    end

    assign stat.undo_empty = (undo_cnt_reg == '0);
    assign stat.redo_empty = (redo_cnt_reg == '0);
    assign stat.op_zero    = (opnd_reg == '0);
    assign stat.div_done   = div_done;

    assign value      = value_reg;
    assign status     = status_reg;
    assign undo_depth = undo_depth_reg;
    assign redo_depth = redo_depth_reg;

endmodule

`default_nettype wire

>>> rtl/urac_ctrl.sv
// Command sequencer of the undo/redo accumulator unit.
`timescale 1ns / 1ps
`default_nettype none

module urac_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire logic [urac_pkg::FUNC_W-1:0] cmd_func,
    output logic                             cmd_ready,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    input  wire urac_pkg::dp_stat_t          stat,
    output urac_pkg::ctl_cmd_t               ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    urac_pkg::func_t   func_reg, func_next;
    urac_pkg::status_t status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        ctl.acc_sel    = urac_pkg::ACC_HOLD;
        ctl.status     = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load    = 1'b1;
                    func_next   = urac_pkg::func_t'(cmd_func);
                    status_next = urac_pkg::ST_OK;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (func_reg)
                    urac_pkg::FUNC_ADD:
                    begin
                        ctl.push_undo  = 1'b1;
                        ctl.clear_redo = 1'b1;
                        ctl.acc_sel    = urac_pkg::ACC_ADD;
                        state_next     = S_DONE;
                    end
                    urac_pkg::FUNC_SUB:
                    begin
                        ctl.push_undo  = 1'b1;
                        ctl.clear_redo = 1'b1;
                        ctl.acc_sel    = urac_pkg::ACC_SUB;
                        state_next     = S_DONE;
                    end
                    urac_pkg::FUNC_MUL:
                    begin
                        ctl.push_undo  = 1'b1;
                        ctl.clear_redo = 1'b1;
                        ctl.acc_sel    = urac_pkg::ACC_MUL;
                        state_next     = S_DONE;
                    end
                    urac_pkg::FUNC_DIV:
                    begin
                        // Divide by zero still pushes and still empties redo.
                        ctl.push_undo  = 1'b1;
                        ctl.clear_redo = 1'b1;
                        if (stat.op_zero)
                        begin
                            status_next = urac_pkg::ST_DIV_ZERO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctl.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    urac_pkg::FUNC_UNDO:
                    begin
                        if (stat.undo_empty)
                        begin
                            status_next = urac_pkg::ST_NO_UNDO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctl.push_redo = 1'b1;
                            ctl.pop_undo  = 1'b1;
                            state_next    = S_POP;
                        end
                    end
                    urac_pkg::FUNC_REDO:
                    begin
                        if (stat.redo_empty)
                        begin
                            status_next = urac_pkg::ST_NO_REDO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctl.push_undo = 1'b1;
                            ctl.pop_redo  = 1'b1;
                            state_next    = S_POP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP:
            begin
                ctl.acc_sel = (func_reg == urac_pkg::FUNC_UNDO) ? urac_pkg::ACC_POP_UNDO
                                                                : urac_pkg::ACC_POP_REDO;
                state_next  = S_DONE;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.acc_sel = urac_pkg::ACC_DIV;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the response register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= urac_pkg::FUNC_ADD;
            status_reg    <= urac_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

>>> rtl/undo_redo_accumulator_unit.sv
// Top level of the undo/redo accumulator unit.
// From accept to response valid, add, subtract, multiply, divide by zero, an empty-stack
// undo or redo and unused codes pass through execute and done; undo and redo add a stack
// read state; divide by a nonzero divisor waits in the divider state until the divider
// finishes. The 32-step shift-subtract divider makes that the slowest command. A command
// is taken while the previous response still waits; done holds until that one is taken.
// Reset (rst_n, async, active low) clears the accumulator, stack counts and pointers and
// the handshake state; stack memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module undo_redo_accumulator_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    urac_cmd_if.sink   cmd,
    urac_rsp_if.source rsp
);

    // Command and status bundles between the sequencer and the datapath.
    urac_pkg::ctl_cmd_t ctl;
    urac_pkg::dp_stat_t stat;

    // Sequencer: takes one command in idle, walks it through execute, a stack
    // read or the divider, then parks the result in the response register.
    urac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_func  (cmd.func),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Datapath: accumulator, the two circular stacks in RAM, the divider and
    // the response payload registers.
    urac_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .operand_in (cmd.operand),
        .stat       (stat),
        .value      (rsp.value),
        .status     (rsp.status),
        .undo_depth (rsp.undo_depth),
        .redo_depth (rsp.redo_depth)
    );

endmodule

`default_nettype wire

>>> rtl/urac_checker.sv
// Port-level assertions of the undo/redo accumulator unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module urac_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [urac_pkg::DATA_W-1:0]   rsp_value,
    input wire logic [urac_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [urac_pkg::DEPTH_W-1:0]  rsp_undo_depth,
    input wire logic [urac_pkg::DEPTH_W-1:0]  rsp_redo_depth
);

    // A stalled response holds its value and status.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)
                                       && $stable(rsp_status)))
        else $error("stalled response changed");

    // No response can appear the cycle right after a command is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && !rsp_valid) |=> !rsp_valid)
        else $error("response too early after command");

    // An empty-stack status matches an empty stack depth.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == urac_pkg::ST_NO_UNDO)) |-> (rsp_undo_depth == '0))
        else $error("nothing-to-undo with nonzero undo depth");

    a_empty_redo: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == urac_pkg::ST_NO_REDO)) |-> (rsp_redo_depth == '0))
        else $error("nothing-to-redo with nonzero redo depth");

    // Divide by zero still pushes and empties redo.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == urac_pkg::ST_DIV_ZERO))
            |-> ((rsp_redo_depth == '0) && (rsp_undo_depth != '0)))
        else $error("divide by zero left stacks inconsistent");

endmodule

bind undo_redo_accumulator_unit urac_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_value      (rsp.value),
    .rsp_status     (rsp.status),
    .rsp_undo_depth (rsp.undo_depth),
    .rsp_redo_depth (rsp.redo_depth)
);

`default_nettype wire
